/* rtl/sum_checked_frame_receiver_core_macros.svh */
// assertion helpers shared by the receiver modules
`ifndef SUM_CHECKED_FRAME_RECEIVER_CORE_MACROS_SVH
`define SUM_CHECKED_FRAME_RECEIVER_CORE_MACROS_SVH

// same-cycle implication, checked on every clock out of reset
`define SFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sfr_pkg.sv */
package sfr_pkg;

  localparam logic [7:0]  SYNC_BYTE      = 8'h68;
  localparam logic [16:0] SYNC2_IDX      = 17'd9;
  localparam logic [16:0] LEN_LO_IDX     = 17'd11;
  localparam logic [16:0] LEN_HI_IDX     = 17'd12;
  localparam int          FRAME_OVERHEAD = 15;
  localparam logic [16:0] LAST_OFS       = 17'(FRAME_OVERHEAD - 1);
  localparam logic [16:0] CSUM_OFS       = 17'(FRAME_OVERHEAD - 2);

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_SYNC = 2'd2;

  typedef enum logic [0:0] {
    PH_HUNT  = 1'b0,
    PH_FRAME = 1'b1
  } phase_t;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic [16:0] byte_index;
    logic        is_last;
    logic [1:0]  status;
  } res_t;

endpackage

/* rtl/sum_checked_frame_receiver_core.sv */
// Frame receiver for a serial byte stream: hunts for a 0x68 start byte, then
// echoes every frame byte with its index, checks the second 0x68 at index 9,
// takes the data length from indexes 11 and 12 (low byte first), and flags the
// frame's last byte with the result of the modulo-256 sum check (status 0
// good, 1 checksum mismatch, 2 second sync byte missing, the latter ending the
// frame at index 9). One byte is accepted every cycle while full is low; each
// accepted byte is classified in the cycle it arrives and, if it belongs to a
// frame, lands in a QUEUE_DEPTH-entry result queue, so it shows on the out_
// ports once it reaches the head of that queue. full rises only when the queue
// is full, i.e. when the consumer holds off pop for QUEUE_DEPTH results. No
// initialization is needed after reset.
module sum_checked_frame_receiver_core
  import sfr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_frame_byte,
  output logic [16:0] out_byte_index,
  output logic        out_is_last,
  output logic [1:0]  out_status
);

  logic acc;
  logic emit;
  res_t res;
  res_t head;

  assign acc = push && !full;

  sfr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .rx_byte (in_rx_byte),
    .emit    (emit),
    .res     (res)
  );

  sfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (emit),
    .wr_data (res),
    .full    (full),
    .rd_en   (pop),
    .empty   (empty),
    .rd_data (head)
  );

  assign out_frame_byte = head.frame_byte;
  assign out_byte_index = head.byte_index;
  assign out_is_last    = head.is_last;
  assign out_status     = head.status;

endmodule

/* rtl/sfr_front.sv */
`include "sum_checked_frame_receiver_core_macros.svh"

module sfr_front
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] rx_byte,
  output logic       emit,
  output res_t       res
);

  phase_t      phase_r, phase_nxt;
  logic [16:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        match_r, match_nxt;

  logic        is_sync;
  logic        sync_err;
  logic        in_hdr;
  logic [16:0] last_idx;
  logic [16:0] csum_idx;
  logic        at_last;
  logic        at_csum;

  assign is_sync  = (rx_byte == SYNC_BYTE);
  assign sync_err = (pos_r == SYNC2_IDX) && !is_sync;
  assign in_hdr   = (pos_r <= LEN_HI_IDX);
  assign last_idx = {1'b0, len_r} + LAST_OFS;
  assign csum_idx = {1'b0, len_r} + CSUM_OFS;
  assign at_last  = !in_hdr && (pos_r >= last_idx);
  assign at_csum  = !in_hdr && (pos_r == csum_idx);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    match_nxt = match_r;
    if (acc) begin
      case (phase_r)
        PH_HUNT: begin
          if (is_sync) begin
            phase_nxt = PH_FRAME;
            pos_nxt   = 17'd1;
            len_nxt   = '0;
            sum_nxt   = rx_byte;
            match_nxt = 1'b0;
          end
        end
        PH_FRAME: begin
          if (sync_err || at_last) begin
            phase_nxt = PH_HUNT;
            pos_nxt   = '0;
          end else begin
            pos_nxt = pos_r + 17'd1;
            if (pos_r == LEN_LO_IDX) begin
              len_nxt = {len_r[15:8], rx_byte};
            end else if (pos_r == LEN_HI_IDX) begin
              len_nxt = {rx_byte, len_r[7:0]};
            end
            if (at_csum) begin
              match_nxt = (sum_r == rx_byte);
            end else begin
              sum_nxt = sum_r + rx_byte;
            end
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          pos_nxt   = '0;
        end
      endcase
    end
  end

  // result of the current item
  always_comb begin
    emit           = 1'b0;
    res.frame_byte = rx_byte;
    res.byte_index = pos_r;
    res.is_last    = 1'b0;
    res.status     = ST_OK;
    case (phase_r)
      PH_HUNT: begin
        emit           = acc && is_sync;
        res.byte_index = '0;
      end
      PH_FRAME: begin
        emit = acc;
        if (sync_err) begin
          res.is_last = 1'b1;
          res.status  = ST_SYNC;
        end else if (at_last) begin
          res.is_last = 1'b1;
          res.status  = match_r ? ST_OK : ST_SUM;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= '0;
      len_r   <= '0;
      sum_r   <= '0;
      match_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      match_r <= match_nxt;
    end
  end

  `SFR_ASSERT_NOW(a_hunt_pos_zero, phase_r == PH_HUNT, pos_r == '0, "position not cleared while hunting")
  `SFR_ASSERT_NEXT(a_last_ends_frame, emit && res.is_last, phase_r == PH_HUNT, "frame did not end on last item")
  `SFR_ASSERT_NOW(a_sync_err_at_nine, emit && (res.status == ST_SYNC), res.byte_index == SYNC2_IDX && res.is_last, "sync error off index 9")
  `SFR_ASSERT_NOW(a_hdr_not_last, emit && (res.byte_index <= LEN_HI_IDX) && (res.byte_index != SYNC2_IDX), !res.is_last, "header byte marked last")

endmodule

/* rtl/sfr_queue.sv */
`include "sum_checked_frame_receiver_core_macros.svh"

module sfr_queue
  import sfr_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  res_t wr_data,
  output logic full,
  input  logic rd_en,
  output logic empty,
  output res_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr;
  logic          do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `SFR_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CW'(DEPTH), "queue count overflow")
  `SFR_ASSERT_NEXT(a_cnt_up, do_wr && !do_rd, cnt_r == $past(cnt_r) + 1'b1, "count did not rise on write")
  `SFR_ASSERT_NEXT(a_cnt_down, do_rd && !do_wr, cnt_r == $past(cnt_r) - 1'b1, "count did not fall on read")
  `SFR_ASSERT_NOW(a_ptr_match, (cnt_r == '0) || (cnt_r == CW'(DEPTH)), wr_ptr_r == rd_ptr_r, "pointers disagree with count")

endmodule

/* tb/sv/sum_checked_frame_receiver_core_tb.sv */
module sum_checked_frame_receiver_core_tb;
  import sfr_pkg::*;

  localparam int ITEM_GOAL = 1800;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_REPORTS = 50;

  typedef struct packed {
    logic [7:0] rx;
    bit         typed;
    bit         yields;
    res_t       want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        full;
  logic        empty;
  logic [7:0]  out_frame_byte;
  logic [16:0] out_byte_index;
  logic        out_is_last;
  logic [1:0]  out_status;

  // receiver state as the checker sees it
  phase_t      rx_phase = PH_HUNT;
  logic [16:0] rx_pos = '0;
  logic [15:0] rx_len = '0;
  logic [7:0]  rx_sum = '0;
  bit          rx_sum_ok = 1'b0;

  res_t     pending_results[$];
  dir_row_t dir_rows[$];
  bit       idle_on = 1'b1;
  int       n_predicted = 0;
  int       n_checked = 0;
  int       n_good = 0;
  int       n_sum_err = 0;
  int       n_sync_err = 0;
  int       n_mismatch = 0;
  int       pop_hold = 0;
  int       quiet = 0;

  sum_checked_frame_receiver_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_rx_byte    (in_rx_byte),
    .empty         (empty),
    .pop           (pop),
    .out_frame_byte(out_frame_byte),
    .out_byte_index(out_byte_index),
    .out_is_last   (out_is_last),
    .out_status    (out_status)
  );

  always #10 clk = ~clk;

  function automatic res_t mk_res(logic [7:0] b, logic [16:0] idx, logic last,
                                  logic [1:0] st);
    res_t r;
    r.frame_byte = b;
    r.byte_index = idx;
    r.is_last = last;
    r.status = st;
    return r;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
    logic [16:0] idx;
    logic [16:0] last_idx;
    r = '0;
    if (rx_phase != PH_FRAME) begin
      if (b != SYNC_BYTE) return 1'b0;
      rx_phase = PH_FRAME;
      rx_pos = 17'd1;
      rx_len = '0;
      rx_sum = b;
      rx_sum_ok = 1'b0;
      r = mk_res(b, 17'd0, 1'b0, ST_OK);
      return 1'b1;
    end
    idx = rx_pos;
    if (idx == 17'd9 && b != SYNC_BYTE) begin
      rx_phase = PH_HUNT;
      rx_pos = '0;
      r = mk_res(b, idx, 1'b1, ST_SYNC);
      return 1'b1;
    end
    if (idx == 17'd11) rx_len[7:0] = b;
    else if (idx == 17'd12) rx_len[15:8] = b;
    if (idx <= 17'd12) begin
      rx_sum = rx_sum + b;
      rx_pos = idx + 17'd1;
      r = mk_res(b, idx, 1'b0, ST_OK);
      return 1'b1;
    end
    last_idx = {1'b0, rx_len} + 17'(FRAME_OVERHEAD - 1);
    if (idx >= last_idx) begin
      rx_phase = PH_HUNT;
      rx_pos = '0;
      r = mk_res(b, idx, 1'b1, rx_sum_ok ? ST_OK : ST_SUM);
      return 1'b1;
    end
    if (idx == last_idx - 17'd1) rx_sum_ok = (rx_sum == b);
    else rx_sum = rx_sum + b;
    rx_pos = idx + 17'd1;
    r = mk_res(b, idx, 1'b0, ST_OK);
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed, input bit yields,
                           input res_t want);
    res_t r;
    bit   have;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    push <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (full);
    have = deframe_byte(b, r);
    if (typed) begin
      have = yields;
      r = want;
    end
    if (have) begin
      pending_results.push_back(r);
      n_predicted++;
    end
    @(negedge clk);
  endtask

  task automatic send_plain(input logic [7:0] b);
    send_byte(b, 1'b0, 1'b0, '0);
  endtask

  task automatic send_frame(input logic [15:0] len, input bit bad_sum, input bit bad_sync);
    logic [7:0] acc;
    logic [7:0] b;
    int         total;
    total = int'(len) + FRAME_OVERHEAD;
    acc = '0;
    for (int i = 0; i < total; i++) begin
      if (i == 0 || (i == 9 && !bad_sync)) begin
        b = SYNC_BYTE;
      end else if (i == 9) begin
        b = 8'($urandom);
        if (b == SYNC_BYTE) b = ~b;
      end else if (i == 11) begin
        b = len[7:0];
      end else if (i == 12) begin
        b = len[15:8];
      end else if (i == total - 2) begin
        b = bad_sum ? acc ^ 8'($urandom_range(1, 255)) : acc;
      end else begin
        b = 8'($urandom);
      end
      send_plain(b);
      acc = acc + b;
      if (i == 9 && bad_sync) return;
    end
  endtask

  // result side: stall bursts, no new ones once idling is switched off
  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold = pop_hold - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      pop_hold = $urandom_range(0, 3);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    res_t got;
    if (rst_n && pop && !empty) begin
      got = {out_frame_byte, out_byte_index, out_is_last, out_status};
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("%0t: unexpected item: byte %02h index %0d last %0b status %0d", $time,
                   got.frame_byte, got.byte_index, got.is_last, got.status);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got.frame_byte !== want.frame_byte || got.byte_index !== want.byte_index ||
            got.is_last !== want.is_last || got.status !== want.status) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS)
            $display("%0t: exp %02h idx %0d last %0b st %0d, got %02h idx %0d last %0b st %0d",
                     $time, want.frame_byte, want.byte_index, want.is_last, want.status,
                     got.frame_byte, got.byte_index, got.is_last, got.status);
        end
        if (want.is_last) begin
          if (want.status == ST_OK) n_good++;
          else if (want.status == ST_SUM) n_sum_err++;
          else n_sync_err++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no traffic for %0d cycles, %0d items outstanding", $time, quiet,
                 pending_results.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int         pick;
    logic [15:0] len;

    // hunting drops, a frame broken at the second sync byte, a minimal good frame
    dir_rows.push_back('{8'h00, 1'b1, 1'b0, '0});
    dir_rows.push_back('{8'hFF, 1'b1, 1'b0, '0});
    dir_rows.push_back('{8'h68, 1'b1, 1'b1, '{8'h68, 17'd0, 1'b0, ST_OK}});
    for (int i = 0; i < 8; i++) dir_rows.push_back('{8'h01 << i, 1'b0, 1'b0, '0});
    dir_rows.push_back('{8'h69, 1'b1, 1'b1, '{8'h69, 17'd9, 1'b1, ST_SYNC}});
    dir_rows.push_back('{8'h68, 1'b1, 1'b1, '{8'h68, 17'd0, 1'b0, ST_OK}});
    dir_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    dir_rows.push_back('{8'hFF, 1'b0, 1'b0, '0});
    dir_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    dir_rows.push_back('{8'hFF, 1'b0, 1'b0, '0});
    dir_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    dir_rows.push_back('{8'hFF, 1'b0, 1'b0, '0});
    dir_rows.push_back('{8'h12, 1'b0, 1'b0, '0});
    dir_rows.push_back('{8'h34, 1'b0, 1'b0, '0});
    dir_rows.push_back('{8'h68, 1'b0, 1'b0, '0});
    dir_rows.push_back('{8'h11, 1'b0, 1'b0, '0});
    dir_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    dir_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    dir_rows.push_back('{8'h24, 1'b0, 1'b0, '0});
    dir_rows.push_back('{8'h16, 1'b1, 1'b1, '{8'h16, 17'd14, 1'b1, ST_OK}});

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].yields,
                                    dir_rows[i].want);

    while (n_predicted < ITEM_GOAL) begin
      if (n_predicted > ITEM_GOAL * 4 / 5) idle_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // line noise between frames, never a start byte
        repeat ($urandom_range(1, 6)) begin
          len[7:0] = 8'($urandom);
          if (len[7:0] == SYNC_BYTE) len[7:0] = ~len[7:0];
          send_plain(len[7:0]);
        end
      end else begin
        len = ($urandom_range(0, 29) == 0) ? 16'($urandom_range(250, 300))
                                           : 16'($urandom_range(0, 24));
        pick = $urandom_range(0, 99);
        send_frame(len, pick >= 75 && pick < 87, pick >= 87);
      end
    end

    idle_on = 1'b0;
    send_frame(16'h0100, 1'b0, 1'b0);
    send_frame(16'd0, 1'b1, 1'b0);

    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("checked %0d frame bytes against the predictor", n_checked);
    $display("frames: %0d good, %0d bad checksum, %0d missing second sync byte",
             n_good, n_sum_err, n_sync_err);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
